/* rtl/tsfp_pkg.sv */
// Shared types and constants for the temperature sensor frame parser.
// No dependencies.
package tsfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TEMP_W      = 15;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned FRAME_BYTES_DEFAULT = 9;

  // Fixed frame header and payload positions
  localparam logic [BYTE_W-1:0] HDR_B0 = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_B1 = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_B2 = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_B3 = 8'h04;
  localparam logic [POS_W-1:0]  POS_HDR0     = 4'd0;
  localparam logic [POS_W-1:0]  POS_HDR1     = 4'd1;
  localparam logic [POS_W-1:0]  POS_HDR2     = 4'd2;
  localparam logic [POS_W-1:0]  POS_HDR3     = 4'd3;
  localparam logic [POS_W-1:0]  POS_WHOLE    = 4'd6;
  localparam logic [POS_W-1:0]  POS_FRACTION = 4'd7;

  localparam logic signed [TEMP_W-1:0] HUNDRED = 15'sd100;

  // Byte held in the input register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } byte_item_t;

  // Parser result for the byte being consumed
  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
  } temp_result_t;

endpackage

/* rtl/tsfp_in_stage.sv */
// Input register stage for the frame parser: holds one received byte.
// Depends on tsfp_pkg.
module tsfp_in_stage import tsfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              in_stall,
  input  logic              consume,
  output byte_item_t        item
);

  byte_item_t item_q;

  // stall only while a held byte cannot move on
  assign in_stall = item_q.valid & ~consume;
  assign item     = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_q.valid <= 1'b1;
    end else if (consume) begin
      item_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q.data <= rx_byte;
    end
  end

endmodule

/* rtl/tsfp_parser.sv */
// Frame parser state: header hunt, position count, checksum, temperature math.
// Depends on tsfp_pkg.
module tsfp_parser import tsfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  byte_item_t   item,
  input  logic         consume,
  output temp_result_t result
);

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]  frame_position, frame_position_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] whole_degrees, whole_degrees_next;
  logic [BYTE_W-1:0] fraction_part, fraction_part_next;
  logic              hdr_fail;
  logic              good;

  logic signed [TEMP_W-1:0] whole_ext;
  logic signed [TEMP_W-1:0] whole_scaled;
  logic signed [TEMP_W-1:0] frac_ext;

  always_comb begin
    case (frame_position)
      POS_HDR1: hdr_fail = (item.data != HDR_B1);
      POS_HDR2: hdr_fail = (item.data != HDR_B2);
      POS_HDR3: hdr_fail = (item.data != HDR_B3);
      default:  hdr_fail = 1'b0;
    endcase
  end

  always_comb begin
    frame_position_next = frame_position;
    running_sum_next    = running_sum;
    whole_degrees_next  = whole_degrees;
    fraction_part_next  = fraction_part;
    good                = 1'b0;
    if (frame_position == POS_HDR0) begin
      // sum restarts with the first header byte
      if (item.data == HDR_B0) begin
        running_sum_next    = item.data;
        frame_position_next = POS_HDR1;
      end
    end else if (hdr_fail) begin
      frame_position_next = POS_HDR0;
    end else begin
      if (frame_position == POS_WHOLE) begin
        whole_degrees_next = item.data;
      end
      if (frame_position == POS_FRACTION) begin
        fraction_part_next = item.data;
      end
      if (frame_position == POS_LAST) begin
        good                = (item.data == running_sum);
        frame_position_next = POS_HDR0;
      end else begin
        running_sum_next    = running_sum + item.data;
        frame_position_next = frame_position + POS_W'(1);
      end
    end
  end

  // whole * 100 +/- fraction; zero counts as non-negative
  assign whole_ext    = TEMP_W'(signed'(whole_degrees));
  assign whole_scaled = whole_ext * HUNDRED;
  assign frac_ext     = signed'(TEMP_W'(fraction_part));

  assign result.valid = item.valid & good;
  assign result.temp  = whole_degrees[BYTE_W-1] ? (whole_scaled - frac_ext)
                                                : (whole_scaled + frac_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= '0;
      running_sum    <= '0;
      whole_degrees  <= '0;
      fraction_part  <= '0;
    end else if (item.valid && consume) begin
      frame_position <= frame_position_next;
      running_sum    <= running_sum_next;
      whole_degrees  <= whole_degrees_next;
      fraction_part  <= fraction_part_next;
    end
  end

endmodule

/* rtl/temp_sensor_frame_parser_core.sv */
// Top level of the temperature sensor frame parser.
// Depends on tsfp_pkg, tsfp_in_stage and tsfp_parser.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received serial
//   byte per transaction. The parser hunts for header 55 01 01 04, collects a
//   frame of FRAME_BYTES bytes and checks the last byte against the 8-bit sum
//   of all earlier frame bytes.
//   Output channel (out_valid / out_stall / temp_hundredths) carries one
//   transaction per good frame: signed temperature in hundredths of a degree.
//   Bad header bytes and bad checksums produce no transaction.
// Path: the frame's last byte is registered in the input register, then parsed
//   into the output register, which holds the result until it is taken.
// Throughput: one byte per cycle while out_stall holds no pending result, set by
//   the parser update between the input register and the output register.
// Reset: rst (synchronous) empties both registers and returns the parser to
//   header hunt with a cleared sum.
// Stall: while out_stall holds a pending result, the held byte waits and
//   in_stall rises once the input register is also full.
module temp_sensor_frame_parser_core import tsfp_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        rx_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TEMP_W-1:0] temp_hundredths
);

  byte_item_t   item;
  temp_result_t result;
  logic         consume;   // parser step may run this cycle
  logic         out_valid_q;
  logic signed [TEMP_W-1:0] temp_q;

  // output register free, or being emptied right now
  assign consume = ~out_valid_q | ~out_stall;

  tsfp_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .rx_byte  (rx_byte),
    .in_stall (in_stall),
    .consume  (consume),
    .item     (item)
  );

  tsfp_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .consume (consume),
    .result  (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && result.valid) begin
      temp_q <= result.temp;
    end
  end

  assign out_valid       = out_valid_q;
  assign temp_hundredths = temp_q;

endmodule

/* tb/sv/temp_sensor_frame_parser_core_tb.sv */
// Self-checking testbench for temp_sensor_frame_parser_core: byte stream in,
// signed temperatures out, checked against an in-bench frame predictor.
// Depends on tsfp_pkg and the RTL of temp_sensor_frame_parser_core.
module temp_sensor_frame_parser_core_tb;
  import tsfp_pkg::*;

  localparam int unsigned FRAME_LEN = FRAME_BYTES_DEFAULT;
  // No-progress limit of the watchdog on both channels.
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned RANDOM_BYTES = 650;
  localparam int unsigned MIN_RESULTS = 40;

  // Frame predictor plus the queue of temperatures still owed by the DUT.
  class temp_frame_board;
    logic [POS_W-1:0]         pos;
    logic [BYTE_W-1:0]        sum;
    logic [BYTE_W-1:0]        whole;
    logic [BYTE_W-1:0]        frac;
    logic signed [TEMP_W-1:0] temps_due[$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              predicted;

    function new();
      pos = POS_HDR0;
      sum = '0;
      whole = '0;
      frac = '0;
      errors = 0;
      checked = 0;
      predicted = 0;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    // One accepted input transaction: advance the parser state and queue a
    // temperature when a frame closes with a good checksum.
    function void take_byte(logic [BYTE_W-1:0] b);
      logic [POS_W-1:0]         p;
      logic signed [BYTE_W-1:0] ws;
      int                       v;
      p = pos;
      if (p == POS_HDR0) begin
        if (b != HDR_B0) return;
        sum = '0;
      end else if ((p == POS_HDR1 && b != HDR_B1) ||
                   (p == POS_HDR2 && b != HDR_B2) ||
                   (p == POS_HDR3 && b != HDR_B3)) begin
        // failing byte is not re-tried as a first header byte
        pos = POS_HDR0;
        return;
      end
      if (p == POS_WHOLE) whole = b;
      if (p == POS_FRACTION) frac = b;
      if (int'(p) + 1 >= int'(FRAME_LEN)) begin
        pos = POS_HDR0;
        if (b == sum) begin
          ws = whole;
          // zero counts as non-negative: fraction added
          v = (ws < 0) ? int'(ws) * 100 - int'(frac) : int'(ws) * 100 + int'(frac);
          temps_due.push_back(TEMP_W'(v));
          predicted++;
        end
        return;
      end
      sum = sum + b;
      pos = p + 1'b1;
    endfunction

    task check_temp(logic signed [TEMP_W-1:0] got);
      logic signed [TEMP_W-1:0] want;
      if (temps_due.size() == 0) begin
        report_mismatch($sformatf("unexpected temperature %0d", got));
        return;
      end
      want = temps_due.pop_front();
      checked++;
      if (got !== want)
        report_mismatch($sformatf("temp_hundredths %0d, predicted %0d", got, want));
    endtask

    function int unsigned pending();
      return temps_due.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        rx_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] temp_hundredths;

  temp_frame_board board = new();

  // calm: both sides run with no gaps and no stalls
  bit          calm = 1'b0;
  int unsigned stuck_cycles = 0;
  int unsigned frames_good = 0;
  int unsigned frames_bad = 0;
  int unsigned headers_broken = 0;
  int unsigned noise_bytes = 0;
  int unsigned frame_bytes = 0;

  temp_sensor_frame_parser_core #(.FRAME_BYTES(FRAME_LEN)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .temp_hundredths(temp_hundredths)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Output side: check each accepted result transaction, randomize stall,
  // and watch for lack of progress on both channels.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_temp(temp_hundredths);
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 34);
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Drive one byte and hold it until accepted; then maybe idle a little.
  // in_valid is only lowered when a gap follows, so it never toggles twice
  // within one time step.
  task push_rx_byte(logic [BYTE_W-1:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    board.take_byte(b);
    if (!calm && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      rx_byte  <= BYTE_W'($urandom);
      // each further idle cycle drawn with the same odds
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 34);
    end
  endtask

  // Full frame: header, filler, whole byte, fraction byte, checksum.
  task send_frame(logic [BYTE_W-1:0] whole, logic [BYTE_W-1:0] frac, bit good);
    logic [BYTE_W-1:0] fb[FRAME_LEN];
    logic [BYTE_W-1:0] cs;
    cs = '0;
    fb[0] = HDR_B0;
    fb[1] = HDR_B1;
    fb[2] = HDR_B2;
    fb[3] = HDR_B3;
    for (int i = 4; i < FRAME_LEN - 1; i++) fb[i] = BYTE_W'($urandom);
    fb[POS_WHOLE] = whole;
    fb[POS_FRACTION] = frac;
    for (int i = 0; i < FRAME_LEN - 1; i++) cs = cs + fb[i];
    fb[FRAME_LEN-1] = good ? cs : cs ^ BYTE_W'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_LEN; i++) push_rx_byte(fb[i]);
    frame_bytes += FRAME_LEN;
    if (good) frames_good++;
    else frames_bad++;
  endtask

  // Header cut short after n good bytes by a wrong one (often 0x55).
  task send_broken_header(int unsigned n);
    logic [BYTE_W-1:0] hdr[4];
    logic [BYTE_W-1:0] bad;
    hdr[0] = HDR_B0;
    hdr[1] = HDR_B1;
    hdr[2] = HDR_B2;
    hdr[3] = HDR_B3;
    for (int i = 0; i < n; i++) push_rx_byte(hdr[i]);
    bad = $urandom_range(0, 1) ? HDR_B0 : BYTE_W'($urandom);
    if (bad == hdr[n]) bad = ~bad;
    push_rx_byte(bad);
    headers_broken++;
  endtask

  function logic [BYTE_W-1:0] pick_whole();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  function logic [BYTE_W-1:0] pick_fraction();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd99;
      2: return 8'd100;
      3: return 8'd255;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sel;
    int unsigned frame_idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: mismatch at each header position, then the coldest and the warmest frame.
    push_rx_byte(8'hFF);
    noise_bytes++;
    send_broken_header(1);
    send_broken_header(2);
    send_broken_header(3);
    send_frame(8'h80, 8'hFF, 1'b1);
    send_frame(8'h7F, 8'hFF, 1'b1);

    // Random: mostly well-formed frames with random content.
    frame_idx = 0;
    while (frame_bytes < RANDOM_BYTES || board.predicted < MIN_RESULTS) begin
      calm = (frame_idx >= 20 && frame_idx < 32);
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        send_frame(pick_whole(), pick_fraction(), 1'b1);
        frame_idx++;
      end else if (sel < 80) begin
        send_frame(pick_whole(), pick_fraction(), 1'b0);
        frame_idx++;
      end else if (sel < 90) begin
        repeat ($urandom_range(1, 4)) begin
          push_rx_byte(BYTE_W'($urandom));
          noise_bytes++;
        end
      end else begin
        send_broken_header($urandom_range(1, 3));
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain: watchdog catches a result that never shows.
    while (board.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d temperatures never arrived", board.pending()));

    $display("Covered %0d good and %0d bad-checksum frames, %0d broken headers, %0d noise bytes",
             frames_good, frames_bad, headers_broken, noise_bytes);
    $display("Checked %0d temperature transactions, %0d mismatches",
             board.checked, board.errors);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tsfp_pkg.sv
rtl/tsfp_in_stage.sv
rtl/tsfp_parser.sv
rtl/temp_sensor_frame_parser_core.sv
tb/sv/temp_sensor_frame_parser_core_tb.sv
